@@ rtl/mcuf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcuf_pkg
// shared widths, codes and helpers for the maze carver
// ----------------------------------------------------------------------------
package mcuf_pkg;

    localparam int XY_W       = 5;
    localparam int DIR_W      = 2;
    localparam int WALLS_W    = 4;
    localparam int SETS_W     = 11;
    localparam int SIDE_W     = 6;
    // clamped side, wide enough for the largest grid side
    localparam int SIDE_EXT_W = 7;
    // cell count of the largest grid plus one bit
    localparam int TOTAL_W    = 13;

    localparam logic [SIDE_W-1:0]     SIDE_RESET = 6'd32;
    localparam logic [SIDE_EXT_W-1:0] SIDE_MIN   = 7'd2;

    localparam logic [WALLS_W-1:0] ALL_WALLS     = 4'hF;
    localparam logic [WALLS_W-1:0] ENTRANCE_MASK = 4'hB;
    localparam logic [WALLS_W-1:0] EXIT_MASK     = 4'hE;

    localparam logic CMD_CARVE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [DIR_W-1:0] DIR_EAST  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
    localparam logic [DIR_W-1:0] DIR_WEST  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_NORTH = 2'd3;

    // grid geometry handed from the config register to the sequencer
    typedef struct packed {
        logic [SIDE_EXT_W-1:0] side;
        logic [TOTAL_W-1:0]    total;
        logic                  restart;
    } geom_t;

    function automatic logic [WALLS_W-1:0] dir_bit(input logic [DIR_W-1:0] dir);
        dir_bit = WALLS_W'(1) << dir;
    endfunction

    // entrance west wall and exit east wall always read open
    function automatic logic [WALLS_W-1:0] show_walls(
        input logic [WALLS_W-1:0] w,
        input logic               at_entrance,
        input logic               at_exit
    );
        logic [WALLS_W-1:0] r;
        r = w;
        if (at_entrance)
        begin
            r = r & ENTRANCE_MASK;
        end
        if (at_exit)
        begin
            r = r & EXIT_MASK;
        end
        show_walls = r;
    endfunction

endpackage

@@ rtl/mcuf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcuf_if
// handshake channels of the maze carver: items, results, config writes
// ----------------------------------------------------------------------------
interface mcuf_item_if;
    import mcuf_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [XY_W-1:0]    cell_x;
    logic [XY_W-1:0]    cell_y;
    logic [DIR_W-1:0]   direction;

    modport source (output valid, cmd, cell_x, cell_y, direction, input ready);
    modport sink   (input valid, cmd, cell_x, cell_y, direction, output ready);
endinterface

interface mcuf_result_if;
    import mcuf_pkg::*;

    logic               valid;
    logic               ready;
    logic [WALLS_W-1:0] walls;
    logic               joined;
    logic [SETS_W-1:0]  sets_left;
    logic               complete;

    modport source (output valid, walls, joined, sets_left, complete, input ready);
    modport sink   (input valid, walls, joined, sets_left, complete, output ready);
endinterface

interface mcuf_cfg_if;
    import mcuf_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIDE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/maze_carver_union_find.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_carver_union_find
// grid maze carver with a union-find set table held in block memory
// ----------------------------------------------------------------------------
// item channel: cmd, cell_x, cell_y, direction; one beat carves a wall or
//   reads a cell, and always produces exactly one result beat
// result channel: walls, joined, sets_left, complete, held in an output
//   register until taken; a stalled receiver holds the block in its final
//   state, the next item is taken as soon as the result is loaded
// cfg channel: one beat writes the side length and restarts the maze
// an accepted item is decoded; an item outside the grid then goes to done,
//   a read or a carve whose neighbor is off the grid reads the wall memory,
//   and a carve walks the parent chains of both cells, one parent read after
//   another on the single read port of the parent memory (chain length is
//   bounded by set size), then writes both walls and a parent if it joins
// one item is in flight at a time; the next item beat is taken in idle,
//   after the result is loaded and while no clearing sweep runs
// reset and each cfg write start a clearing sweep over all SIDE_MAX*SIDE_MAX
//   cells that rewrites both memories; no item is taken during the sweep
// ----------------------------------------------------------------------------
module maze_carver_union_find #(
    parameter int SIDE_MAX = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    mcuf_item_if.sink     item,
    mcuf_result_if.source result,
    mcuf_cfg_if.sink      cfg
);
    import mcuf_pkg::*;

    logic [SIDE_W-1:0]     side_reg, side_next;
    logic [SIDE_EXT_W-1:0] side_ext;
    logic [SIDE_EXT_W-1:0] side_used;
    logic                  cfg_write;
    geom_t                 geom;

    // config is always accepted
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        side_next = cfg_write ? cfg.data : side_reg;
    end

    // side clamped into the supported range
    always_comb
    begin
        side_ext = SIDE_EXT_W'(side_reg);
        if (side_ext < SIDE_MIN)
        begin
            side_used = SIDE_MIN;
        end
        else if (side_ext > SIDE_EXT_W'(SIDE_MAX))
        begin
            side_used = SIDE_EXT_W'(SIDE_MAX);
        end
        else
        begin
            side_used = side_ext;
        end
    end

    // total cell count of the active grid, restart pulse on every write
    assign geom.side    = side_used;
    assign geom.total   = TOTAL_W'(side_used) * TOTAL_W'(side_used);
    assign geom.restart = cfg_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
        end
        else
        begin
            side_reg <= side_next;
        end
    end

    mcuf_core #(.SIDE_MAX(SIDE_MAX)) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .geom   (geom)
    );

endmodule

@@ rtl/mcuf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcuf_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mcuf_ram #(
    parameter int   WIDTH = 4,
    parameter int   DEPTH = 1024,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mcuf_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcuf_core
// carve and read sequencer over the wall and parent memories
// ----------------------------------------------------------------------------
module mcuf_core #(
    parameter int SIDE_MAX = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mcuf_item_if.sink            item,
    mcuf_result_if.source        result,
    input  mcuf_pkg::geom_t      geom
);
    import mcuf_pkg::*;

    localparam int CELLS  = SIDE_MAX * SIDE_MAX;
    localparam int CELL_W = $clog2(CELLS);

    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] ROW_STEP  = CELL_W'(SIDE_MAX);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_RD_WALL = 3'd2;
    localparam logic [2:0] S_WALK_A  = 3'd3;
    localparam logic [2:0] S_WALK_B  = 3'd4;
    localparam logic [2:0] S_JOIN_A  = 3'd5;
    localparam logic [2:0] S_JOIN_B  = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    // control
    logic [2:0]         state_reg, state_next;
    logic               first_reg, first_next;
    logic [CELL_W-1:0]  join_reg, join_next;
    logic               clr_busy_reg, clr_busy_next;
    logic [CELL_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic               cmd_reg, cmd_next;
    logic [XY_W-1:0]    x_reg, x_next;
    logic [XY_W-1:0]    y_reg, y_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [CELL_W-1:0]  here_reg, here_next;
    logic [CELL_W-1:0]  there_reg, there_next;
    logic [CELL_W-1:0]  cur_reg, cur_next;
    logic [CELL_W-1:0]  root_a_reg, root_a_next;
    logic [WALLS_W-1:0] wall_here_reg, wall_here_next;
    logic [WALLS_W-1:0] wall_there_reg, wall_there_next;
    logic [WALLS_W-1:0] res_walls_reg, res_walls_next;
    logic               res_joined_reg, res_joined_next;
    logic [WALLS_W-1:0] out_walls_reg, out_walls_next;
    logic               out_joined_reg, out_joined_next;
    logic [SETS_W-1:0]  out_sets_reg, out_sets_next;
    logic               out_complete_reg, out_complete_next;

    // memory ports
    logic               wall_we;
    logic [CELL_W-1:0]  wall_waddr, wall_raddr;
    logic [WALLS_W-1:0] wall_wdata, wall_rdata;
    logic               par_we;
    logic [CELL_W-1:0]  par_waddr, par_raddr;
    logic [CELL_W-1:0]  par_wdata, par_rdata;

    // decode of the held item
    logic [SIDE_EXT_W-1:0] x_ext, y_ext;
    logic                  in_grid, nb_ok, at_entrance, at_exit;
    logic [CELL_W-1:0]     here_calc, there_calc;
    logic [TOTAL_W-1:0]    sets_calc;
    logic                  accept;

    mcuf_ram #(.WIDTH(WALLS_W), .DEPTH(CELLS)) u_wall_ram (
        .clk   (clk),
        .we    (wall_we),
        .waddr (wall_waddr),
        .wdata (wall_wdata),
        .raddr (wall_raddr),
        .rdata (wall_rdata)
    );

    mcuf_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_par_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    assign item.ready        = (state_reg == S_IDLE) && !clr_busy_reg;
    assign accept            = item.valid && item.ready;
    assign result.valid      = out_valid_reg;
    assign result.walls      = out_walls_reg;
    assign result.joined     = out_joined_reg;
    assign result.sets_left  = out_sets_reg;
    assign result.complete   = out_complete_reg;

    always_comb
    begin
        x_ext       = SIDE_EXT_W'(x_reg);
        y_ext       = SIDE_EXT_W'(y_reg);
        in_grid     = (x_ext < geom.side) && (y_ext < geom.side);
        at_entrance = (x_reg == '0) && (y_reg == '0);
        at_exit     = (x_ext == geom.side - SIDE_EXT_W'(1))
                   && (y_ext == geom.side - SIDE_EXT_W'(1));
        here_calc   = CELL_W'(y_reg) * ROW_STEP + CELL_W'(x_reg);
        case (dir_reg)
            DIR_EAST:
            begin
                nb_ok      = (x_ext + SIDE_EXT_W'(1)) < geom.side;
                there_calc = here_calc + CELL_W'(1);
            end
            DIR_SOUTH:
            begin
                nb_ok      = (y_ext + SIDE_EXT_W'(1)) < geom.side;
                there_calc = here_calc + ROW_STEP;
            end
            DIR_WEST:
            begin
                nb_ok      = (x_reg != '0);
                there_calc = here_calc - CELL_W'(1);
            end
            default:
            begin
                nb_ok      = (y_reg != '0);
                there_calc = here_calc - ROW_STEP;
            end
        endcase
        sets_calc = geom.total - TOTAL_W'(join_reg);
    end

    always_comb
    begin
        state_next        = state_reg;
        first_next        = first_reg;
        join_next         = join_reg;
        clr_busy_next     = clr_busy_reg;
        clr_addr_next     = clr_addr_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        cmd_next          = cmd_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        dir_next          = dir_reg;
        here_next         = here_reg;
        there_next        = there_reg;
        cur_next          = cur_reg;
        root_a_next       = root_a_reg;
        wall_here_next    = wall_here_reg;
        wall_there_next   = wall_there_reg;
        res_walls_next    = res_walls_reg;
        res_joined_next   = res_joined_reg;
        out_walls_next    = out_walls_reg;
        out_joined_next   = out_joined_reg;
        out_sets_next     = out_sets_reg;
        out_complete_next = out_complete_reg;
        wall_we           = 1'b0;
        wall_waddr        = here_reg;
        wall_wdata        = ALL_WALLS;
        wall_raddr        = here_reg;
        par_we            = 1'b0;
        par_waddr         = root_a_reg;
        par_wdata         = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = item.cmd;
                    x_next     = item.cell_x;
                    y_next     = item.cell_y;
                    dir_next   = item.direction;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                here_next  = here_calc;
                there_next = there_calc;
                wall_raddr = here_calc;
                cur_next   = here_calc;
                first_next = 1'b1;
                if (!in_grid)
                begin
                    res_walls_next  = ALL_WALLS;
                    res_joined_next = 1'b0;
                    state_next      = S_DONE;
                end
                else if (cmd_reg == CMD_CARVE && nb_ok)
                begin
                    state_next = S_WALK_A;
                end
                else
                begin
                    state_next = S_RD_WALL;
                end
            end
            S_RD_WALL:
            begin
                res_walls_next  = show_walls(wall_rdata, at_entrance, at_exit);
                res_joined_next = 1'b0;
                state_next      = S_DONE;
            end
            S_WALK_A:
            begin
                // first beat of data is still the cell's own walls
                wall_raddr = there_reg;
                if (first_reg)
                begin
                    wall_here_next = wall_rdata;
                    first_next     = 1'b0;
                end
                if (par_rdata == cur_reg)
                begin
                    root_a_next = cur_reg;
                    cur_next    = there_reg;
                    state_next  = S_WALK_B;
                end
                else
                begin
                    cur_next = par_rdata;
                end
            end
            S_WALK_B:
            begin
                wall_raddr      = there_reg;
                wall_there_next = wall_rdata;
                if (par_rdata == cur_reg)
                begin
                    if (root_a_reg != cur_reg)
                    begin
                        state_next = S_JOIN_A;
                    end
                    else
                    begin
                        res_walls_next  = show_walls(wall_here_reg, at_entrance, at_exit);
                        res_joined_next = 1'b0;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    cur_next = par_rdata;
                end
            end
            S_JOIN_A:
            begin
                // root of the neighbor sits in cur_reg
                wall_we    = 1'b1;
                wall_waddr = here_reg;
                wall_wdata = wall_here_reg & ~dir_bit(dir_reg);
                par_we     = 1'b1;
                par_waddr  = root_a_reg;
                par_wdata  = cur_reg;
                join_next  = join_reg + CELL_W'(1);
                state_next = S_JOIN_B;
            end
            S_JOIN_B:
            begin
                wall_we         = 1'b1;
                wall_waddr      = there_reg;
                wall_wdata      = wall_there_reg & ~dir_bit(dir_reg + DIR_W'(2));
                res_walls_next  = show_walls(wall_here_reg & ~dir_bit(dir_reg),
                                             at_entrance, at_exit);
                res_joined_next = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_walls_next    = res_walls_reg;
                    out_joined_next   = res_joined_reg;
                    out_sets_next     = SETS_W'(sets_calc);
                    out_complete_next = (sets_calc == TOTAL_W'(1));
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // next parent lookup follows the walk pointer
        par_raddr = cur_next;

        // clearing sweep owns the write ports
        if (clr_busy_reg)
        begin
            wall_we    = 1'b1;
            wall_waddr = clr_addr_reg;
            wall_wdata = ALL_WALLS;
            par_we     = 1'b1;
            par_waddr  = clr_addr_reg;
            par_wdata  = clr_addr_reg;
            clr_addr_next = clr_addr_reg + CELL_W'(1);
            if (clr_addr_reg == LAST_CELL)
            begin
                clr_busy_next = 1'b0;
            end
        end

        if (geom.restart)
        begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
            join_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b0;
            join_reg      <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            join_reg      <= join_next;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        x_reg            <= x_next;
        y_reg            <= y_next;
        dir_reg          <= dir_next;
        here_reg         <= here_next;
        there_reg        <= there_next;
        cur_reg          <= cur_next;
        root_a_reg       <= root_a_next;
        wall_here_reg    <= wall_here_next;
        wall_there_reg   <= wall_there_next;
        res_walls_reg    <= res_walls_next;
        res_joined_reg   <= res_joined_next;
        out_walls_reg    <= out_walls_next;
        out_joined_reg   <= out_joined_next;
        out_sets_reg     <= out_sets_next;
        out_complete_reg <= out_complete_next;
    end

endmodule
